[rtl/message_segmenter_macros.svh]
// assertion macros for the message segmenter
`ifndef MESSAGE_SEGMENTER_MACROS_SVH
`define MESSAGE_SEGMENTER_MACROS_SVH

`ifndef SYNTH
`define MSG_SEG_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("message_segmenter assertion failed");
`define MSG_SEG_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("message_segmenter assertion failed");
`else
`define MSG_SEG_ASSERT_SAME(label, clk, rst, ante, cons)
`define MSG_SEG_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

[rtl/msg_seg_pkg.sv]
// constants and types shared by the message segmenter files
package msg_seg_pkg;

  localparam int BYTE_W            = 8;
  localparam int LEN_W             = 17;
  localparam int CHUNK_W           = 13;
  localparam int CHUNK_CNT_W       = 12;
  localparam int FRAG_IDX_W        = 16;
  localparam int SEQ_W             = 32;
  localparam int MAX_MESSAGE_BYTES = 65536;
  localparam int MAX_CHUNK_BYTES   = 4096;
  localparam int SHORT_LIMIT       = 8;
  localparam int HEADER_BYTES      = 24;
  localparam int HDR_CNT_W         = 5;
  localparam int DIV_STEPS         = LEN_W;
  localparam int DIV_CNT_W         = 5;
  localparam int CFG_INDEX_W       = 1;
  localparam int CFG_DATA_W        = 32;

  localparam logic [CHUNK_W-1:0] CHUNK_RESET = CHUNK_W'(1024);
  localparam logic [SEQ_W-1:0]   LIMIT_RESET = SEQ_W'(65535);

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_CHUNK_SIZE     = 1'b0,
    REG_SEQUENCE_LIMIT = 1'b1
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_HDR  = 4'b0100,
    ST_PAY  = 4'b1000
  } seg_state_t;

endpackage

[rtl/msg_seg_if.sv]
// stream and configuration interfaces of the message segmenter
interface msg_seg_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [msg_seg_pkg::BYTE_W-1:0]        data_byte;
  logic [msg_seg_pkg::LEN_W-1:0]         message_length;

  modport source (output valid, output data_byte, output message_length, input ready);
  modport sink (input valid, input data_byte, input message_length, output ready);
endinterface

interface msg_seg_out_if;
  logic                                  valid;
  logic                                  ready;
  logic [msg_seg_pkg::BYTE_W-1:0]        out_byte;
  logic                                  is_header;
  logic                                  end_of_fragment;
  logic                                  end_of_message;
  logic                                  last_of_run;

  modport source (output valid, output out_byte, output is_header, output end_of_fragment,
                  output end_of_message, output last_of_run, input ready);
  modport sink (input valid, input out_byte, input is_header, input end_of_fragment,
                input end_of_message, input last_of_run, output ready);
endinterface

interface msg_seg_cfg_if;
  logic                                  valid;
  logic                                  ready;
  logic [msg_seg_pkg::CFG_INDEX_W-1:0]   index;
  logic [msg_seg_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/message_segmenter.sv]
// message segmenter: a taken payload byte is registered out before the next byte is taken
// a chunk start adds 24 header bytes ahead of its payload byte
// the first byte of a long message first runs the bit-serial fragment count divider
// header bytes leave via the output register one per cycle, sink permitting, input held off
// output register lets the next byte in while the last result waits on the sink
// synchronous active-high reset clears the sequencer, counters and restores register defaults
`include "message_segmenter_macros.svh"

module message_segmenter (
  input  logic          clk,
  input  logic          rst,
  msg_seg_in_if.sink    message,
  msg_seg_out_if.source fragment,
  msg_seg_cfg_if.sink   cfg
);
  import msg_seg_pkg::*;

  seg_state_t               state;
  logic [CHUNK_W-1:0]       chunk_size;
  logic [SEQ_W-1:0]         sequence_limit;
  logic [SEQ_W-1:0]         next_sequence;
  logic [SEQ_W-1:0]         message_sequence;
  logic [LEN_W-1:0]         fragment_total;
  logic [FRAG_IDX_W-1:0]    fragment_index;
  logic [LEN_W-1:0]         byte_in_message;
  logic [CHUNK_CNT_W-1:0]   byte_in_chunk;
  logic [LEN_W-1:0]         held_length;
  logic [CHUNK_W-1:0]       held_chunk;
  logic [DIV_CNT_W-1:0]     div_cnt;
  logic [LEN_W-1:0]         div_quo;
  logic [CHUNK_W-1:0]       div_rem;
  logic [HDR_CNT_W-1:0]     hdr_cnt;
  logic [BYTE_W-1:0]        data_hold;

  logic [BYTE_W-1:0]        out_byte;
  logic                     out_hdr;
  logic                     out_eof;
  logic                     out_eom;
  logic                     out_last;
  logic                     out_valid;

  logic                     in_fire;
  logic                     out_free;
  logic                     first_byte;
  logic [LEN_W-1:0]         sat_len;
  logic [CHUNK_W-1:0]       sat_chunk;
  logic [LEN_W-1:0]         eff_len;
  logic [SEQ_W-1:0]         seq_inc;
  logic [CHUNK_W:0]         div_trial;
  logic                     div_ge;
  logic [CHUNK_W-1:0]       div_rem_next;
  logic [LEN_W-1:0]         div_quo_next;
  logic [SEQ_W-1:0]         hdr_word;
  logic [BYTE_W-1:0]        hdr_byte;
  logic                     hdr_last;
  logic                     pay_eom;
  logic                     pay_eof;
  logic [CHUNK_W-1:0]       bic_ext;

  assign cfg.ready       = 1'b1;
  assign message.ready   = (state == ST_IDLE);
  assign in_fire         = message.valid && message.ready;
  assign out_free        = !out_valid || fragment.ready;

  assign fragment.valid           = out_valid;
  assign fragment.out_byte        = out_byte;
  assign fragment.is_header       = out_hdr;
  assign fragment.end_of_fragment = out_eof;
  assign fragment.end_of_message  = out_eom;
  assign fragment.last_of_run     = out_last;

  assign first_byte = (byte_in_message == '0);

  always_comb begin
    if (message.message_length > LEN_W'(MAX_MESSAGE_BYTES)) begin
      sat_len = LEN_W'(MAX_MESSAGE_BYTES);
    end else begin
      sat_len = message.message_length;
    end
    if (chunk_size == '0) begin
      sat_chunk = CHUNK_W'(1);
    end else if (chunk_size > CHUNK_W'(MAX_CHUNK_BYTES)) begin
      sat_chunk = CHUNK_W'(MAX_CHUNK_BYTES);
    end else begin
      sat_chunk = chunk_size;
    end
  end

  assign eff_len = first_byte ? sat_len : held_length;
  assign seq_inc = next_sequence + SEQ_W'(1);

  // one restoring division step per cycle: fragment count = ceil(length / chunk)
  assign div_trial    = {div_rem, div_quo[LEN_W-1]};
  assign div_ge       = (div_trial >= {1'b0, held_chunk});
  assign div_rem_next = div_ge ? CHUNK_W'(div_trial - {1'b0, held_chunk})
                               : div_trial[CHUNK_W-1:0];
  assign div_quo_next = {div_quo[LEN_W-2:0], div_ge};

  // header: sequence, count, index as little-endian 64-bit words
  always_comb begin
    case (hdr_cnt[HDR_CNT_W-1:3])
      2'd0:    hdr_word = message_sequence;
      2'd1:    hdr_word = SEQ_W'(fragment_total);
      default: hdr_word = SEQ_W'(fragment_index);
    endcase
    hdr_byte = hdr_cnt[2] ? '0 : BYTE_W'(hdr_word >> {hdr_cnt[1:0], 3'b000});
  end

  assign hdr_last = (hdr_cnt == HDR_CNT_W'(HEADER_BYTES - 1));

  assign pay_eom = ({1'b0, byte_in_message} + (LEN_W+1)'(1)) >= {1'b0, held_length};
  assign bic_ext = {1'b0, byte_in_chunk};
  assign pay_eof = pay_eom || ((bic_ext + CHUNK_W'(1)) >= held_chunk);

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      chunk_size       <= CHUNK_RESET;
      sequence_limit   <= LIMIT_RESET;
      next_sequence    <= '0;
      message_sequence <= '0;
      fragment_total   <= '0;
      fragment_index   <= '0;
      byte_in_message  <= '0;
      byte_in_chunk    <= '0;
      held_length      <= '0;
      held_chunk       <= CHUNK_W'(1);
      div_cnt          <= '0;
      hdr_cnt          <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        unique case (cfg_reg_t'(cfg.index))
          REG_CHUNK_SIZE:     chunk_size <= cfg.data[CHUNK_W-1:0];
          REG_SEQUENCE_LIMIT: sequence_limit <= cfg.data[SEQ_W-1:0];
          default:            ;
        endcase
      end

      if (out_valid && fragment.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (in_fire && !(first_byte && message.message_length == '0)) begin
            data_hold <= message.data_byte;
            if (first_byte) begin
              held_length    <= sat_len;
              held_chunk     <= sat_chunk;
              byte_in_chunk  <= '0;
              fragment_index <= '0;
            end
            if (eff_len <= LEN_W'(SHORT_LIMIT)) begin
              // short message: count bytes silently
              if (({1'b0, byte_in_message} + (LEN_W+1)'(1)) >= {1'b0, eff_len}) begin
                byte_in_message <= '0;
              end else begin
                byte_in_message <= byte_in_message + LEN_W'(1);
              end
            end else if (first_byte) begin
              message_sequence <= next_sequence;
              next_sequence    <= (seq_inc > sequence_limit) ? '0 : seq_inc;
              div_quo          <= sat_len;
              div_rem          <= '0;
              div_cnt          <= DIV_CNT_W'(DIV_STEPS);
              state            <= ST_DIV;
            end else if (byte_in_chunk == '0) begin
              hdr_cnt <= '0;
              state   <= ST_HDR;
            end else begin
              state <= ST_PAY;
            end
          end
        end
        ST_DIV: begin
          div_quo <= div_quo_next;
          div_rem <= div_rem_next;
          div_cnt <= div_cnt - DIV_CNT_W'(1);
          if (div_cnt == DIV_CNT_W'(1)) begin
            fragment_total <= div_quo_next + LEN_W'(div_rem_next != '0);
            hdr_cnt        <= '0;
            state          <= ST_HDR;
          end
        end
        ST_HDR: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_byte  <= hdr_byte;
            out_hdr   <= 1'b1;
            out_eof   <= 1'b0;
            out_eom   <= 1'b0;
            out_last  <= 1'b0;
            hdr_cnt   <= hdr_cnt + HDR_CNT_W'(1);
            if (hdr_last) begin
              state <= ST_PAY;
            end
          end
        end
        ST_PAY: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_byte  <= data_hold;
            out_hdr   <= 1'b0;
            out_eof   <= pay_eof;
            out_eom   <= pay_eom;
            out_last  <= 1'b1;
            byte_in_message <= pay_eom ? '0 : byte_in_message + LEN_W'(1);
            byte_in_chunk   <= pay_eof ? '0 : byte_in_chunk + CHUNK_CNT_W'(1);
            if (pay_eom) begin
              fragment_index <= '0;
            end else if (pay_eof) begin
              fragment_index <= fragment_index + FRAG_IDX_W'(1);
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `MSG_SEG_ASSERT_SAME(a_hdr_flags, clk, rst, out_valid && out_hdr,
                       !out_eof && !out_eom && !out_last)
  `MSG_SEG_ASSERT_NEXT(a_hdr_to_pay, clk, rst, state == ST_HDR && out_free && hdr_last,
                       state == ST_PAY)
  `MSG_SEG_ASSERT_SAME(a_chunk_pos, clk, rst, state == ST_IDLE, bic_ext < held_chunk)

endmodule
